[src/cftp_pkg.sv]
// ============================================================================
// cftp_pkg
// Shared types and constants for the cube face texel projection pipeline.
// ============================================================================
package cftp_pkg;

    localparam int COMP_W      = 16;
    localparam int CFG_W       = 13;
    localparam int TEXEL_W     = 12;
    localparam int FACE_W      = 3;
    localparam int MINOR_W     = COMP_W + 1;
    localparam int DIV_W       = COMP_W + 1;
    localparam int QUO_W       = 13;
    localparam int REM_W       = 30;
    localparam int MAX_FACE_WIDTH = 4096;
    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(256);
    localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_FACE_WIDTH);

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    // word travelling through the divider stages
    typedef struct packed {
        logic [FACE_W-1:0] face;
        logic              degenerate;
        logic [DIV_W-1:0]  divisor;
        logic [REM_W-1:0]  rem_u;
        logic [REM_W-1:0]  rem_v;
        logic [QUO_W-1:0]  quo_u;
        logic [QUO_W-1:0]  quo_v;
    } div_t;

endpackage

[src/cube_face_texel_projection_unit.sv]
// ============================================================================
// cube_face_texel_projection_unit
// Picks the cube face of a direction and projects it to a texel column/row.
//
//   channel   ports                  dir   contents
//   s_        tvalid/tready/tdata    in    direction word
//   m_        tvalid/tready/tdata    out   face and texel word, tuser flag
//   cfg_      valid/ready/data       in    face_width register
//
// Sustains one word per clock while m_tready is high; it has three front stages, 13
// divider stages (one quotient bit each) and one output register.
// Reset clears all stage valid bits and sets face_width to 256.
// A stalled output holds its word; each stage fills while the next is busy,
// so bubbles close up and nothing is lost or repeated.
// cfg_ready is always high.
// ============================================================================
module cube_face_texel_projection_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // dir_x[15:0], dir_y[31:16], dir_z[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // face[2:0], texel_col[14:3], texel_row[26:15], zero
    output logic        m_tuser,   // degenerate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [cftp_pkg::CFG_W-1:0] cfg_data
);

    localparam int STAGES = cftp_pkg::QUO_W;

    logic [cftp_pkg::CFG_W-1:0] face_width_reg;
    logic [cftp_pkg::CFG_W-1:0] width_eff;

    cftp_pkg::div_t chain_data  [STAGES+1];
    logic           chain_valid [STAGES+1];
    logic           chain_ready [STAGES+1];

    logic [cftp_pkg::FACE_W-1:0]  face;
    logic [cftp_pkg::TEXEL_W-1:0] texel_col, texel_row;
    logic                         degenerate;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_width_reg <= cftp_pkg::WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            face_width_reg <= cfg_data;
        end
    end

    assign width_eff = (face_width_reg > cftp_pkg::WIDTH_MAX) ? cftp_pkg::WIDTH_MAX
                                                               : face_width_reg;

    cftp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .dir_x     (s_tdata[15:0]),
        .dir_y     (s_tdata[31:16]),
        .dir_z     (s_tdata[47:32]),
        .width     (width_eff),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < STAGES; i++) begin : g_div
        cftp_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    cftp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (chain_valid[STAGES]),
        .in_ready   (chain_ready[STAGES]),
        .in_data    (chain_data[STAGES]),
        .width      (width_eff),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .face       (face),
        .texel_col  (texel_col),
        .texel_row  (texel_row),
        .degenerate (degenerate)
    );

    assign m_tdata = {5'b00000, texel_row, texel_col, face};
    assign m_tuser = degenerate;

    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

endmodule

[src/cftp_front.sv]
// ============================================================================
// cftp_front
// Face selection, minor offset and scaling by face width: three stages.
// ============================================================================
module cftp_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [cftp_pkg::COMP_W-1:0]  dir_x,
    input  logic signed [cftp_pkg::COMP_W-1:0]  dir_y,
    input  logic signed [cftp_pkg::COMP_W-1:0]  dir_z,
    input  logic [cftp_pkg::CFG_W-1:0]          width,
    output logic                                out_valid,
    input  logic                                out_ready,
    output cftp_pkg::div_t                      out_data
);

    typedef struct packed {
        logic [cftp_pkg::FACE_W-1:0]         face;
        logic                                degenerate;
        logic [cftp_pkg::COMP_W-1:0]         mag;
        logic signed [cftp_pkg::MINOR_W-1:0] minor_u;
        logic signed [cftp_pkg::MINOR_W-1:0] minor_v;
    } sel_t;

    typedef struct packed {
        logic [cftp_pkg::FACE_W-1:0]  face;
        logic                         degenerate;
        logic [cftp_pkg::DIV_W-1:0]   divisor;
        logic [cftp_pkg::MINOR_W-1:0] num_u;
        logic [cftp_pkg::MINOR_W-1:0] num_v;
    } off_t;

    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic a_ready, b_ready, c_ready;
    sel_t a_reg, a_next;
    off_t b_reg, b_next;
    cftp_pkg::div_t c_reg, c_next;

    logic [cftp_pkg::COMP_W-1:0]         ax, ay, az;
    logic signed [cftp_pkg::MINOR_W-1:0] px, py, pz, nx, ny, nz;
    logic [cftp_pkg::MINOR_W:0]          sum_u, sum_v;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage A: magnitudes and face choice
    always_comb begin
        ax = dir_x[cftp_pkg::COMP_W-1] ? cftp_pkg::COMP_W'(-dir_x) : cftp_pkg::COMP_W'(dir_x);
        ay = dir_y[cftp_pkg::COMP_W-1] ? cftp_pkg::COMP_W'(-dir_y) : cftp_pkg::COMP_W'(dir_y);
        az = dir_z[cftp_pkg::COMP_W-1] ? cftp_pkg::COMP_W'(-dir_z) : cftp_pkg::COMP_W'(dir_z);
        px = cftp_pkg::MINOR_W'(dir_x);
        py = cftp_pkg::MINOR_W'(dir_y);
        pz = cftp_pkg::MINOR_W'(dir_z);
        nx = -px;
        ny = -py;
        nz = -pz;
        a_next.degenerate = (ax == '0) && (ay == '0) && (az == '0);
        if ((ax >= ay) && (ax >= az)) begin
            a_next.mag = ax;
            a_next.minor_v = ny;
            if (!dir_x[cftp_pkg::COMP_W-1] && !a_next.degenerate) begin
                a_next.face    = cftp_pkg::FACE_POS_X;
                a_next.minor_u = nz;
            end else begin
                a_next.face    = a_next.degenerate ? cftp_pkg::FACE_POS_X
                                                   : cftp_pkg::FACE_NEG_X;
                a_next.minor_u = pz;
            end
        end else if (ay >= az) begin
            a_next.mag     = ay;
            a_next.minor_u = px;
            if (!dir_y[cftp_pkg::COMP_W-1]) begin
                a_next.face    = cftp_pkg::FACE_POS_Y;
                a_next.minor_v = pz;
            end else begin
                a_next.face    = cftp_pkg::FACE_NEG_Y;
                a_next.minor_v = nz;
            end
        end else begin
            a_next.mag     = az;
            a_next.minor_v = ny;
            if (!dir_z[cftp_pkg::COMP_W-1]) begin
                a_next.face    = cftp_pkg::FACE_POS_Z;
                a_next.minor_u = px;
            end else begin
                a_next.face    = cftp_pkg::FACE_NEG_Z;
                a_next.minor_u = nx;
            end
        end
    end

    // stage B: minor + |major| lies in 0 .. 2|major|
    always_comb begin
        sum_u = {a_reg.minor_u[cftp_pkg::MINOR_W-1], a_reg.minor_u}
              + {2'b00, a_reg.mag};
        sum_v = {a_reg.minor_v[cftp_pkg::MINOR_W-1], a_reg.minor_v}
              + {2'b00, a_reg.mag};
        b_next.face       = a_reg.face;
        b_next.degenerate = a_reg.degenerate;
        b_next.divisor    = {a_reg.mag, 1'b0};
        b_next.num_u      = sum_u[cftp_pkg::MINOR_W-1:0];
        b_next.num_v      = sum_v[cftp_pkg::MINOR_W-1:0];
    end

    // stage C: scale by face width
    always_comb begin
        c_next.face       = b_reg.face;
        c_next.degenerate = b_reg.degenerate;
        c_next.divisor    = b_reg.divisor;
        c_next.rem_u      = cftp_pkg::REM_W'(b_reg.num_u) * cftp_pkg::REM_W'(width);
        c_next.rem_v      = cftp_pkg::REM_W'(b_reg.num_v) * cftp_pkg::REM_W'(width);
        c_next.quo_u      = '0;
        c_next.quo_v      = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_reg <= a_next;
        end
        if (a_valid_reg && b_ready) begin
            b_reg <= b_next;
        end
        if (b_valid_reg && c_ready) begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_reg;

endmodule

[src/cftp_div_stage.sv]
// ============================================================================
// cftp_div_stage
// One restoring division step per lane: one quotient bit, registered.
// ============================================================================
module cftp_div_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cftp_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cftp_pkg::div_t out_data
);

    localparam int STEP_W = cftp_pkg::REM_W + 1;

    logic           valid_reg;
    cftp_pkg::div_t data_reg, data_next;
    logic [cftp_pkg::REM_W-1:0] shifted;
    logic [STEP_W-1:0]          step_u, step_v;

    // returns {quotient bit, next remainder}
    function automatic logic [STEP_W-1:0] div_step(
        input logic [cftp_pkg::REM_W-1:0] rem,
        input logic [cftp_pkg::REM_W-1:0] dshift
    );
        logic [STEP_W-1:0]          diff;
        logic [cftp_pkg::REM_W-1:0] kept;
        diff = {1'b0, rem} - {1'b0, dshift};
        kept = diff[STEP_W-1] ? rem : diff[cftp_pkg::REM_W-1:0];
        return {!diff[STEP_W-1], kept[cftp_pkg::REM_W-2:0], 1'b0};
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        shifted = cftp_pkg::REM_W'({in_data.divisor, {(cftp_pkg::QUO_W-1){1'b0}}});
        step_u  = div_step(in_data.rem_u, shifted);
        step_v  = div_step(in_data.rem_v, shifted);
        data_next       = in_data;
        data_next.rem_u = step_u[cftp_pkg::REM_W-1:0];
        data_next.rem_v = step_v[cftp_pkg::REM_W-1:0];
        data_next.quo_u = {in_data.quo_u[cftp_pkg::QUO_W-2:0], step_u[STEP_W-1]};
        data_next.quo_v = {in_data.quo_v[cftp_pkg::QUO_W-2:0], step_v[STEP_W-1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[src/cftp_back.sv]
// ============================================================================
// cftp_back
// Clamp to face width minus one, zero degenerate words, output register.
// ============================================================================
module cftp_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  cftp_pkg::div_t                      in_data,
    input  logic [cftp_pkg::CFG_W-1:0]          width,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cftp_pkg::FACE_W-1:0]         face,
    output logic [cftp_pkg::TEXEL_W-1:0]        texel_col,
    output logic [cftp_pkg::TEXEL_W-1:0]        texel_row,
    output logic                                degenerate
);

    logic                         valid_reg;
    logic [cftp_pkg::FACE_W-1:0]  face_reg, face_next;
    logic [cftp_pkg::TEXEL_W-1:0] col_reg, col_next, row_reg, row_next;
    logic                         deg_reg, deg_next;

    function automatic logic [cftp_pkg::TEXEL_W-1:0] clamp_texel(
        input logic [cftp_pkg::QUO_W-1:0] quo,
        input logic [cftp_pkg::CFG_W-1:0] w
    );
        logic [cftp_pkg::CFG_W-1:0] top;
        top = w - 1'b1;
        if (w == '0) begin
            return '0;
        end else if (cftp_pkg::CFG_W'(quo) >= w) begin
            return top[cftp_pkg::TEXEL_W-1:0];
        end else begin
            return quo[cftp_pkg::TEXEL_W-1:0];
        end
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        deg_next = in_data.degenerate;
        if (in_data.degenerate) begin
            face_next = cftp_pkg::FACE_POS_X;
            col_next  = '0;
            row_next  = '0;
        end else begin
            face_next = in_data.face;
            col_next  = clamp_texel(in_data.quo_u, width);
            row_next  = clamp_texel(in_data.quo_v, width);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            face_reg <= face_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            deg_reg  <= deg_next;
        end
    end

    assign out_valid  = valid_reg;
    assign face       = face_reg;
    assign texel_col  = col_reg;
    assign texel_row  = row_reg;
    assign degenerate = deg_reg;

    a_face_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (face_reg <= cftp_pkg::FACE_NEG_Z))
        else $error("face code out of range");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && deg_reg) |->
            (face_reg == cftp_pkg::FACE_POS_X && col_reg == '0 && row_reg == '0))
        else $error("degenerate word carries non-zero fields");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: cube face texel projection unit testbench
// Streams directions into the unit and checks the face, texel column, texel
// row and degenerate flag of every output word against a face projection
// computed here, with bursty input, a rotating output stall pattern and
// face width changes between drained phases.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_DIRS = 900;
    localparam int PHASE_DIRS = 150;

    typedef struct {
        logic [cftp_pkg::FACE_W-1:0]  face;
        logic [cftp_pkg::TEXEL_W-1:0] col;
        logic [cftp_pkg::TEXEL_W-1:0] row;
        logic                         degenerate;
    } texel_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata = '0;   // dir_x, dir_y, dir_z
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;        // face, texel_col, texel_row, zero
    logic               m_tuser;        // degenerate
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [cftp_pkg::CFG_W-1:0] cfg_data = '0;

    texel_result_t      expected_texels[$];
    logic [cftp_pkg::CFG_W-1:0] width_setting = cftp_pkg::WIDTH_RESET;
    int                 error_count = 0;
    int                 burst_left = 0;
    int                 idle_cycles = 0;
    int                 rx_hold = 0;
    logic [15:0]        rx_pattern = 16'hFFFF;

    cube_face_texel_projection_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic logic [cftp_pkg::TEXEL_W-1:0] texel_index(int minor, int mag, int w);
        longint num;
        longint t;
        if (w == 0) return '0;
        num = longint'(minor + mag) * w;
        t = num / (2 * longint'(mag));
        if (t > w - 1) t = w - 1;
        return t[cftp_pkg::TEXEL_W-1:0];
    endfunction

    function automatic texel_result_t project_direction(
        logic signed [cftp_pkg::COMP_W-1:0] dx,
        logic signed [cftp_pkg::COMP_W-1:0] dy,
        logic signed [cftp_pkg::COMP_W-1:0] dz,
        logic [cftp_pkg::CFG_W-1:0] wreg);
        texel_result_t r;
        int x, y, z, ax, ay, az, mag, nu, nv, w;
        x = int'(dx);
        y = int'(dy);
        z = int'(dz);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        w = (int'(wreg) > cftp_pkg::MAX_FACE_WIDTH) ? cftp_pkg::MAX_FACE_WIDTH : int'(wreg);
        r.face = '0;
        r.col = '0;
        r.row = '0;
        r.degenerate = 1'b0;
        if (ax == 0 && ay == 0 && az == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        if (ax >= ay && ax >= az) begin
            mag = ax;
            nv = -y;
            if (x > 0) begin
                r.face = cftp_pkg::FACE_POS_X;
                nu = -z;
            end else begin
                r.face = cftp_pkg::FACE_NEG_X;
                nu = z;
            end
        end else if (ay >= az) begin
            mag = ay;
            nu = x;
            if (y > 0) begin
                r.face = cftp_pkg::FACE_POS_Y;
                nv = z;
            end else begin
                r.face = cftp_pkg::FACE_NEG_Y;
                nv = -z;
            end
        end else begin
            mag = az;
            nv = -y;
            if (z > 0) begin
                r.face = cftp_pkg::FACE_POS_Z;
                nu = x;
            end else begin
                r.face = cftp_pkg::FACE_NEG_Z;
                nu = -x;
            end
        end
        r.col = texel_index(nu, mag, w);
        r.row = texel_index(nv, mag, w);
        return r;
    endfunction

    // sender: bursts of random length, random gaps between them
    task automatic send_dir(input logic signed [cftp_pkg::COMP_W-1:0] dx,
                            input logic signed [cftp_pkg::COMP_W-1:0] dy,
                            input logic signed [cftp_pkg::COMP_W-1:0] dz);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {dz, dy, dx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_texels.insert(expected_texels.size(),
                               project_direction(dx, dy, dz, width_setting));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_texels.size() != 0) @(posedge aclk);
    endtask

    task automatic write_face_width(input logic [cftp_pkg::CFG_W-1:0] w);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= w;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        width_setting = w;
    endtask

    task automatic send_random_dir();
        logic signed [cftp_pkg::COMP_W-1:0] c[3];
        int j, k;
        for (int i = 0; i < 3; i++) c[i] = cftp_pkg::COMP_W'($urandom);
        j = $urandom_range(0, 2);
        k = (j + 1 + $urandom_range(0, 1)) % 3;
        case ($urandom_range(0, 9))
            4: begin
                for (int i = 0; i < 3; i++) begin
                    c[i] = cftp_pkg::COMP_W'($urandom_range(0, 8)) - 16'sd4;
                end
            end
            5: c[k] = $urandom_range(0, 1) ? c[j] : -c[j];
            6: begin
                for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, 1) ? c[j] : -c[j];
            end
            7: c[j] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            8: begin
                for (int i = 0; i < 3; i++) c[i] = '0;
                if ($urandom_range(0, 3) != 0) begin
                    c[j] = cftp_pkg::COMP_W'($urandom_range(0, 2)) - 16'sd1;
                end
            end
            9: begin
                for (int i = 0; i < 3; i++) c[i] = c[i] >>> $urandom_range(0, 15);
            end
            default: ;
        endcase
        send_dir(c[0], c[1], c[2]);
    endtask

    task automatic test_face_extremes();
        send_dir(16'sh7FFF, 16'sd0, 16'sd0);
        send_dir(16'sh8000, 16'sd0, 16'sd0);
        send_dir(16'sd0, 16'sh7FFF, -16'sd5);
        send_dir(16'sd0, 16'sh8000, 16'sd5);
        send_dir(16'sd3, -16'sd4, 16'sh7FFF);
        send_dir(-16'sd3, 16'sd4, 16'sh8000);
    endtask

    task automatic test_tie_order();
        send_dir(16'sd9, 16'sd9, 16'sd9);
        send_dir(-16'sd9, 16'sd9, -16'sd9);
        send_dir(16'sd0, -16'sd9, 16'sd9);
        send_dir(16'sd0, 16'sd9, -16'sd9);
        send_dir(16'sd1, 16'sh8000, 16'sh8000);
        send_dir(16'sh8000, 16'sh8000, 16'sh8000);
    endtask

    task automatic test_zero_vector();
        send_dir(16'sd0, 16'sd0, 16'sd0);
    endtask

    task automatic test_edge_clamp();
        send_dir(16'sd100, 16'sd100, -16'sd100);
        send_dir(-16'sd7, 16'sd7, 16'sd7);
        send_dir(16'sd2, -16'sd9, 16'sd9);
        send_dir(16'sd9, 16'sd2, 16'sd9);
    endtask

    task automatic test_width_extremes();
        logic [cftp_pkg::CFG_W-1:0] widths[4];
        widths = '{13'd1, cftp_pkg::WIDTH_MAX, 13'd0, 13'h1FFF};
        foreach (widths[i]) begin
            write_face_width(widths[i]);
            send_dir(16'sd1000, -16'sd999, 16'sd999);
            send_dir(-16'sd1, 16'sd0, 16'sd0);
        end
    endtask

    task automatic test_random_stream();
        logic [cftp_pkg::CFG_W-1:0] widths[6];
        widths = '{cftp_pkg::WIDTH_RESET, 13'd2, 13'd4095, 13'd3,
                   cftp_pkg::CFG_W'($urandom_range(1, 4096)),
                   cftp_pkg::CFG_W'($urandom_range(4097, 8191))};
        for (int n = 0; n < RANDOM_DIRS; n++) begin
            if (n % PHASE_DIRS == 0) write_face_width(widths[n / PHASE_DIRS]);
            send_random_dir();
        end
    endtask

    // receiver: rotating stall pattern, reloaded now and then
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_hold = $urandom_range(32, 256);
            rx_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
        end else begin
            rx_hold = rx_hold - 1;
            rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
        m_tready <= rx_pattern[0];
    end

    always @(posedge aclk) begin
        texel_result_t exp_r;
        if (m_tvalid && m_tready) begin
            if (expected_texels.size() == 0) begin
                $error("output word with no expectation waiting: %h", m_tdata);
                error_count++;
            end else begin
                exp_r = expected_texels.pop_front();
                if (m_tdata[2:0] !== exp_r.face) begin
                    $error("face: expected %0d, got %0d", exp_r.face, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[14:3] !== exp_r.col) begin
                    $error("texel_col: expected %0d, got %0d", exp_r.col, m_tdata[14:3]);
                    error_count++;
                end
                if (m_tdata[26:15] !== exp_r.row) begin
                    $error("texel_row: expected %0d, got %0d", exp_r.row, m_tdata[26:15]);
                    error_count++;
                end
                if (m_tuser !== exp_r.degenerate) begin
                    $error("degenerate: expected %0d, got %0d", exp_r.degenerate, m_tuser);
                    error_count++;
                end
                if (m_tdata[31:27] !== '0) begin
                    $error("padding: expected 0, got %0h", m_tdata[31:27]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_face_extremes();
        test_tie_order();
        test_zero_vector();
        test_edge_clamp();
        test_width_extremes();
        test_random_stream();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_texels.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
